// ===== rtl/core/force_to_intensity_curve_macros.svh =====
// Assertion macros for the force-to-intensity curve block.
`ifndef FORCE_TO_INTENSITY_CURVE_MACROS_SVH
`define FORCE_TO_INTENSITY_CURVE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define FTIC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ftic: implication check failed");
// next-cycle implication
`define FTIC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ftic: next-cycle check failed");
`else
`define FTIC_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define FTIC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/ftic_pkg.sv =====
package ftic_pkg;

  // fractional bits of log2 / exp2 datapath
  localparam int LOG_FRAC = 16;
  localparam logic [15:0] GAMMA_ONE = 16'd4096;
  localparam int EXP_CUTOFF = 40;

  typedef enum logic [7:0] {
    REG_DEADBAND   = 8'd0,
    REG_FULL_SCALE = 8'd1,
    REG_EXPONENT   = 8'd2,
    REG_STEPS      = 8'd3,
    REG_FLOOR      = 8'd4,
    REG_CEILING    = 8'd5
  } reg_index_t;

  // early-out result that rides along the pipe
  typedef struct packed {
    logic       forced;
    logic [7:0] duty;
  } ctl_t;

  // integer square root, elaboration only
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    v   = v_in;
    res = '0;
    b   = 64'h1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (b > v) b = b >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (b != 0) begin
        if (v >= res + b) begin
          v   = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
    end
    return res;
  endfunction

  // factor 2^(-2^-n) in Q0.32, n = 1..LOG_FRAC
  function automatic logic [31:0] exp_root(input int n);
    logic [63:0] r;
    r = 64'h8000_0000;
    for (int k = 1; k <= LOG_FRAC; k++) begin
      if (k <= n) r = isqrt64(r << 32);
    end
    return r[31:0];
  endfunction

endpackage

// ===== rtl/core/force_to_intensity_curve.sv =====
// Channel  | Direction | Signals                          | Handshake
// ---------+-----------+----------------------------------+------------------------
// input    | in        | force_sample, sample_invalid     | in_valid / in_stall
// output   | out       | motor_duty                       | out_valid / out_stall
// config   | in        | cfg_index, cfg_data              | cfg_valid / cfg_ready
//
// One word per cycle sustained unless the output stalls; the pipe holds the
// one-bit-per-stage normalizing divider, 16 log2 squaring stages, 16 exp2
// multiply stages and the 8-stage quantizer divider.
// Reset (rst, synchronous) clears the valid bits and loads register defaults.
// A stall at the output freezes the whole pipe in place; in_stall follows it.
// cfg_ready is always high; the sender must write only while the pipe is empty (not enforced here).
`include "force_to_intensity_curve_macros.svh"
module force_to_intensity_curve import ftic_pkg::*; #(
  parameter int FORCE_WIDTH    = 32,
  parameter int NORM_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [FORCE_WIDTH-1:0] force_sample,
  input  logic                          sample_invalid,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    motor_duty,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [7:0]                    cfg_index,
  input  logic [31:0]                   cfg_data
);

  localparam int FW  = FORCE_WIDTH;
  localparam int NF  = NORM_FRAC_BITS;
  localparam int CW  = (FW > 31) ? FW : 31;  // compare width less sign
  localparam int IW  = $clog2(NF + 1);       // integer part of -log2
  localparam int PW  = $clog2(NF);           // msb position
  localparam int LW  = IW + LOG_FRAC;        // -log2 value
  localparam int IPW = IW + 5;               // integer part of exponent
  localparam int NS  = NF + 50;              // stage count

  // stage indexes
  localparam int ST_N  = NF + 2;
  localparam int ST_X  = NF + 38;
  localparam int ST_F  = NS - 1;

  localparam logic [NF:0]   NORM_ONE = {1'b1, {NF{1'b0}}};
  localparam logic [NF+1:0] CLAMP_ONE = {2'b01, {NF{1'b0}}};
  localparam logic [33:0]   EXP_RND  = 34'(1) << (31 - NF);
  localparam logic [NF+8:0] Q_HALF   = (NF + 9)'(1) << (NF - 1);

  typedef struct packed {
    logic        byp;
    logic [NF:0] bval;
  } shp_t;

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [30:0] deadband_force;
  logic [30:0] full_scale_force;
  logic [15:0] curve_exponent;
  logic [7:0]  step_count;
  logic [7:0]  duty_floor;
  logic [7:0]  duty_ceiling;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband_force   <= 31'd32768;
      full_scale_force <= 31'd655360;
      curve_exponent   <= GAMMA_ONE;
      step_count       <= 8'd0;
      duty_floor       <= 8'd0;
      duty_ceiling     <= 8'd255;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_DEADBAND:   deadband_force   <= cfg_data[30:0];
        REG_FULL_SCALE: full_scale_force <= cfg_data[30:0];
        REG_EXPONENT:   curve_exponent   <= cfg_data[15:0];
        REG_STEPS:      step_count       <= cfg_data[7:0];
        REG_FLOOR:      duty_floor       <= cfg_data[7:0];
        REG_CEILING:    duty_ceiling     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // values derived from config; static while words are in flight only if the sender keeps to that rule
  logic        span_pos;
  logic [30:0] span;
  logic [7:0]  steps_s;
  logic [8:0]  q_den;
  logic [7:0]  d_span;
  logic        quant_on;

  assign span_pos = full_scale_force > deadband_force;
  assign span     = full_scale_force - deadband_force;
  assign steps_s  = step_count - 8'd1;
  assign q_den    = {steps_s, 1'b0};
  assign d_span   = duty_ceiling - duty_floor;
  assign quant_on = step_count >= 8'd2;

  // ---------------------------------------------------------------------
  // pipe control: one enable for all stages
  // ---------------------------------------------------------------------
  logic          adv;
  logic [NS-1:0] vld;
  ctl_t          ctl [NS];

  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], in_valid};
    end
  end

  for (genvar s = 2; s < NS; s++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (adv) ctl[s] <= ctl[s-1];
    end
  end

  // ---------------------------------------------------------------------
  // stage 0: magnitude
  // ---------------------------------------------------------------------
  logic [FW-1:0] raw;
  logic [FW-1:0] a0_mag;
  logic          a0_inv;

  assign raw = force_sample;

  always_ff @(posedge clk) begin
    if (adv) begin
      // most negative input wraps to 2^(FW-1), which is its magnitude
      a0_mag <= raw[FW-1] ? (~raw + 1'b1) : raw;
      a0_inv <= sample_invalid;
    end
  end

  // ---------------------------------------------------------------------
  // stage 1: deadband, early outs, excess over deadband
  // ---------------------------------------------------------------------
  logic [CW:0]   mag_ext;
  logic [CW:0]   db_ext;
  logic [CW:0]   span_ext;
  logic [CW:0]   diff;
  logic          at_dead;

  logic [31:0]   dv_rem  [NF+1];
  logic [NF-1:0] dv_q    [NF+1];
  logic          dv_full [NF+1];

  assign mag_ext  = {{(CW + 1 - FW){1'b0}}, a0_mag};
  assign db_ext   = {{(CW - 30){1'b0}}, deadband_force};
  assign span_ext = {{(CW - 30){1'b0}}, span};
  assign diff     = mag_ext - db_ext;
  assign at_dead  = mag_ext <= db_ext;

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl[1].forced <= a0_inv || at_dead || (duty_ceiling < duty_floor);
      ctl[1].duty   <= (a0_inv || at_dead) ? 8'd0 : duty_floor;
      // no positive span: anything past the deadband is full scale
      dv_full[0]    <= !span_pos || (diff >= span_ext);
      dv_rem[0]     <= diff[31:0];
      dv_q[0]       <= '0;
    end
  end

  // ---------------------------------------------------------------------
  // normalizing divider: diff * 2^NF / span, one quotient bit per stage
  // ---------------------------------------------------------------------
  for (genvar k = 0; k < NF; k++) begin : g_div
    logic [31:0] t;
    logic        ge;
    assign t  = {dv_rem[k][30:0], 1'b0};
    assign ge = t >= {1'b0, span};
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem[k+1]  <= ge ? (t - {1'b0, span}) : t;
        dv_q[k+1]    <= {dv_q[k][NF-2:0], ge};
        dv_full[k+1] <= dv_full[k];
      end
    end
  end

  // ---------------------------------------------------------------------
  // stage N: normalized value and shaping short cuts
  // ---------------------------------------------------------------------
  logic [NF:0]   norm;
  shp_t          n_shp_c;
  logic [NF-1:0] n_norm;
  shp_t          n_shp;

  assign norm = dv_full[NF] ? NORM_ONE : {1'b0, dv_q[NF]};

  always_comb begin
    n_shp_c.byp  = 1'b1;
    n_shp_c.bval = NORM_ONE;
    if (curve_exponent == GAMMA_ONE) begin
      n_shp_c.bval = norm;                 // linear
    end else if (curve_exponent == 16'd0) begin
      n_shp_c.bval = NORM_ONE;             // x^0, zero included
    end else if (norm == '0) begin
      n_shp_c.bval = '0;
    end else if (norm[NF]) begin
      n_shp_c.bval = NORM_ONE;
    end else begin
      n_shp_c.byp  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_norm <= norm[NF-1:0];
      n_shp  <= n_shp_c;
    end
  end

  // ---------------------------------------------------------------------
  // stage P: normalize into [1,2) as Q1.30; squares are Q2.30
  // ---------------------------------------------------------------------
  logic [PW-1:0] msb;
  logic [30:0]   n_wide;
  logic [4:0]    n_sh;

  logic [30:0]   lg_m    [LOG_FRAC+1];
  logic [15:0]   lg_frac [LOG_FRAC+1];
  logic [IW-1:0] lg_int  [LOG_FRAC+1];
  shp_t          lg_shp  [LOG_FRAC+1];

  always_comb begin
    msb = '0;
    for (int i = 0; i < NF; i++) begin
      if (n_norm[i]) msb = PW'(i);
    end
  end

  assign n_wide = 31'(n_norm);
  assign n_sh   = 5'd30 - 5'(msb);

  always_ff @(posedge clk) begin
    if (adv) begin
      lg_m[0]    <= n_wide << n_sh;
      lg_int[0]  <= IW'(NF) - IW'(msb);
      lg_frac[0] <= '0;
      lg_shp[0]  <= n_shp;
    end
  end

  // ---------------------------------------------------------------------
  // log2 fraction: one squaring per stage
  // ---------------------------------------------------------------------
  for (genvar j = 0; j < LOG_FRAC; j++) begin : g_log
    logic [61:0] sq;
    logic [31:0] mm;
    assign sq = {31'd0, lg_m[j]} * {31'd0, lg_m[j]};
    assign mm = sq[61:30];
    always_ff @(posedge clk) begin
      if (adv) begin
        lg_m[j+1]    <= mm[31] ? mm[31:1] : mm[30:0];
        lg_frac[j+1] <= {lg_frac[j][14:0], mm[31]};
        lg_int[j+1]  <= lg_int[j];
        lg_shp[j+1]  <= lg_shp[j];
      end
    end
  end

  // ---------------------------------------------------------------------
  // stage L: -log2 magnitude; stage G: times gamma, rounded to Q.16
  // ---------------------------------------------------------------------
  logic [LW-1:0]  l_val;
  shp_t           l_shp;
  logic [LW+16:0] e_sum;

  logic [32:0]     ex_acc [LOG_FRAC+1];
  logic [IPW-1:0]  ex_ip  [LOG_FRAC+1];
  logic [15:0]     ex_fp  [LOG_FRAC+1];
  shp_t            ex_shp [LOG_FRAC+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      l_val <= {lg_int[LOG_FRAC], {LOG_FRAC{1'b0}}} - {{IW{1'b0}}, lg_frac[LOG_FRAC]};
      l_shp <= lg_shp[LOG_FRAC];
    end
  end

  assign e_sum = (LW + 17)'(l_val) * (LW + 17)'(curve_exponent) + (LW + 17)'(2048);

  always_ff @(posedge clk) begin
    if (adv) begin
      ex_ip[0]  <= e_sum[LW+16:28];
      ex_fp[0]  <= e_sum[27:12];
      ex_acc[0] <= 33'h1_0000_0000;
      ex_shp[0] <= l_shp;
    end
  end

  // ---------------------------------------------------------------------
  // exp2 of the fraction: one root factor per stage
  // ---------------------------------------------------------------------
  for (genvar i = 1; i <= LOG_FRAC; i++) begin : g_exp
    localparam logic [31:0] ROOT = exp_root(i);
    logic [64:0] pr;
    assign pr = {32'd0, ex_acc[i-1]} * {33'd0, ROOT};
    always_ff @(posedge clk) begin
      if (adv) begin
        ex_acc[i] <= ex_fp[i-1][LOG_FRAC-i] ? pr[64:32] : ex_acc[i-1];
        ex_ip[i]  <= ex_ip[i-1];
        ex_fp[i]  <= ex_fp[i-1];
        ex_shp[i] <= ex_shp[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // stage X: integer shift, round to NF bits, clamp, apply short cuts
  // ---------------------------------------------------------------------
  logic [32:0]   x_sh;
  logic [33:0]   x_rnd;
  logic [NF+1:0] x_out;
  logic [NF:0]   x_clamp;
  logic [NF:0]   x_shaped;

  assign x_sh  = ex_acc[LOG_FRAC] >> ex_ip[LOG_FRAC][5:0];
  assign x_rnd = {1'b0, x_sh} + EXP_RND;
  assign x_out = x_rnd[33:32-NF];

  always_comb begin
    if (ex_ip[LOG_FRAC] >= IPW'(EXP_CUTOFF)) begin
      x_clamp = '0;
    end else if (x_out > CLAMP_ONE) begin
      x_clamp = NORM_ONE;
    end else begin
      x_clamp = x_out[NF:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_shaped <= ex_shp[LOG_FRAC].byp ? ex_shp[LOG_FRAC].bval : x_clamp;
    end
  end

  // ---------------------------------------------------------------------
  // Q1: quantizer level and linear duty offset
  // ---------------------------------------------------------------------
  logic [NF+8:0] kp;
  logic [NF+8:0] lp;
  logic [7:0]    q1_k;
  logic [7:0]    q1_lin;

  assign kp = (NF + 9)'(x_shaped) * (NF + 9)'(steps_s) + Q_HALF;
  assign lp = (NF + 9)'(x_shaped) * (NF + 9)'(d_span) + Q_HALF;

  always_ff @(posedge clk) begin
    if (adv) begin
      q1_k   <= kp[NF+7:NF];
      q1_lin <= lp[NF+7:NF];
    end
  end

  // ---------------------------------------------------------------------
  // Q2: numerator 2*k*d + s; then 8-stage divide by 2*s
  // ---------------------------------------------------------------------
  logic [15:0] kd;
  logic [16:0] qnum;

  logic [8:0]  dq_rem [9];
  logic [7:0]  dq_low [9];
  logic [7:0]  dq_q   [9];
  logic [7:0]  dq_lin [9];

  assign kd   = 16'(q1_k) * 16'(d_span);
  assign qnum = {kd, 1'b0} + 17'(steps_s);

  always_ff @(posedge clk) begin
    if (adv) begin
      // quotient never exceeds d, so the upper bits start below the divisor
      dq_rem[0] <= qnum[16:8];
      dq_low[0] <= qnum[7:0];
      dq_q[0]   <= '0;
      dq_lin[0] <= q1_lin;
    end
  end

  for (genvar i = 0; i < 8; i++) begin : g_qdiv
    logic [9:0] t;
    logic       ge;
    assign t  = {dq_rem[i], dq_low[i][7-i]};
    assign ge = t >= {1'b0, q_den};
    always_ff @(posedge clk) begin
      if (adv) begin
        dq_rem[i+1] <= ge ? 9'(t - {1'b0, q_den}) : t[8:0];
        dq_low[i+1] <= dq_low[i];
        dq_q[i+1]   <= {dq_q[i][6:0], ge};
        dq_lin[i+1] <= dq_lin[i];
      end
    end
  end

  // ---------------------------------------------------------------------
  // F: floor offset, ceiling clamp, early-out override
  // ---------------------------------------------------------------------
  logic [7:0] f_val;
  logic [8:0] f_sum;

  assign f_val = quant_on ? dq_q[8] : dq_lin[8];
  assign f_sum = {1'b0, duty_floor} + {1'b0, f_val};

  always_ff @(posedge clk) begin
    if (adv) begin
      if (ctl[ST_F-1].forced) begin
        motor_duty <= ctl[ST_F-1].duty;
      end else if (f_sum > {1'b0, duty_ceiling}) begin
        motor_duty <= duty_ceiling;
      end else begin
        motor_duty <= f_sum[7:0];
      end
    end
  end

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  `FTIC_ASSERT_IMPL(a_duty_range, clk, rst, out_valid && !ctl[ST_F].forced, motor_duty >= duty_floor && motor_duty <= duty_ceiling)
  `FTIC_ASSERT_IMPL(a_shaped_max, clk, rst, vld[ST_X], x_shaped <= NORM_ONE)
  `FTIC_ASSERT_IMPL(a_qdiv_bound, clk, rst, vld[ST_F-1] && quant_on && !ctl[ST_F-1].forced, dq_q[8] <= d_span)
  `FTIC_ASSERT_NEXT(a_stall_hold, clk, rst, vld[ST_N] && !adv, vld[ST_N] && $stable(n_norm))

endmodule
